[rtl/core/cst_pkg.sv]
// Package for the CSV stream tokenizer: token and parser state types, character
// constants and the per-byte parsing functions shared by the step logic.
// No dependencies.
package cst_pkg;

    localparam logic [7:0] BOM0     = 8'hEF;
    localparam logic [7:0] BOM1     = 8'hBB;
    localparam logic [7:0] BOM2     = 8'hBF;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Largest number of tokens one request can produce.
    localparam int unsigned MAX_TOKENS = 3;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BOM_START = 2'd0,
        BOM_EF    = 2'd1,
        BOM_EFBB  = 2'd2,
        BOM_PAST  = 2'd3
    } bom_t;

    typedef struct packed {
        logic in_quoted;
        logic quote_seen;
        logic after_cr;
        logic row_has_data;
        logic field_has_data;
        logic row_started;
    } parse_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       empty;
    } tok_t;

    typedef struct packed {
        parse_t st;
        tok_t   tok;
    } step_t;

    function automatic step_t data_fn(parse_t st, logic [7:0] c);
        step_t r;
        r                      = '0;
        r.st                   = st;
        r.st.field_has_data    = 1'b1;
        r.tok.valid            = 1'b1;
        r.tok.kind             = KIND_DATA;
        r.tok.data             = c;
        return r;
    endfunction

    function automatic step_t rowend_fn(parse_t st);
        step_t r;
        r                   = '0;
        r.st                = st;
        r.tok.valid         = 1'b1;
        r.tok.kind          = KIND_ROW;
        r.tok.empty         = ~(st.row_has_data | st.field_has_data);
        r.st.row_has_data   = 1'b0;
        r.st.field_has_data = 1'b0;
        r.st.row_started    = 1'b0;
        return r;
    endfunction

    // Handling of a byte outside quotes.
    function automatic step_t plain_fn(parse_t st, logic [7:0] c);
        step_t r;
        r    = '0;
        r.st = st;
        if (c == CH_QUOTE)
        begin
            r.st.in_quoted = 1'b1;
        end
        else if (c == CH_COMMA)
        begin
            r.tok.valid         = 1'b1;
            r.tok.kind          = KIND_FIELD;
            r.st.row_started    = 1'b1;
            r.st.row_has_data   = st.row_has_data | st.field_has_data;
            r.st.field_has_data = 1'b0;
        end
        else if (c inside {CH_CR, CH_LF})
        begin
            r             = rowend_fn(st);
            r.st.after_cr = (c == CH_CR);
        end
        else
        begin
            r = data_fn(st, c);
        end
        return r;
    endfunction

    // Handling of one stream byte; yields at most one token.
    function automatic step_t body_fn(parse_t st, logic [7:0] c);
        step_t r;
        logic  skip;
        r    = '0;
        r.st = st;
        skip = 1'b0;
        if (st.after_cr)
        begin
            r.st.after_cr = 1'b0;
            skip          = (c == CH_LF);
        end
        if (!skip)
        begin
            if (r.st.in_quoted)
            begin
                if (r.st.quote_seen)
                begin
                    r.st.quote_seen = 1'b0;
                    if (c == CH_QUOTE)
                    begin
                        r = data_fn(r.st, c);
                    end
                    else
                    begin
                        r.st.in_quoted = 1'b0;
                        r              = plain_fn(r.st, c);
                    end
                end
                else if (c == CH_QUOTE)
                begin
                    r.st.quote_seen = 1'b1;
                end
                else
                begin
                    r = data_fn(r.st, c);
                end
            end
            else
            begin
                r = plain_fn(r.st, c);
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/cst_step.sv]
// Combinational step logic of the CSV stream tokenizer: byte order mark match,
// replay of a partial mark and up to three tokens for one request.
// Depends on cst_pkg.
module cst_step (
    input  logic                                  cmd,
    input  logic [7:0]                            in_byte,
    input  cst_pkg::bom_t                         bom_phase,
    input  cst_pkg::parse_t                       parse,
    output cst_pkg::bom_t                         bom_next,
    output cst_pkg::parse_t                       parse_next,
    output cst_pkg::tok_t [cst_pkg::MAX_TOKENS-1:0] toks
);
    import cst_pkg::*;

    logic [2:0] en;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    step_t      r0;
    step_t      r1;
    step_t      r2;
    step_t      eos;

    // The bytes to feed through the parser, in order, with their enables.
    always_comb
    begin
        en       = 3'b000;
        b0       = BOM0;
        b1       = BOM1;
        b2       = in_byte;
        bom_next = bom_phase;
        if (cmd)
        begin
            en[0]    = (bom_phase == BOM_EF) || (bom_phase == BOM_EFBB);
            en[1]    = (bom_phase == BOM_EFBB);
            bom_next = BOM_START;
        end
        else
        begin
            case (bom_phase)
                BOM_START:
                begin
                    if (in_byte == BOM0)
                    begin
                        bom_next = BOM_EF;
                    end
                    else
                    begin
                        bom_next = BOM_PAST;
                        en[2]    = 1'b1;
                    end
                end
                BOM_EF:
                begin
                    if (in_byte == BOM1)
                    begin
                        bom_next = BOM_EFBB;
                    end
                    else
                    begin
                        bom_next = BOM_PAST;
                        en[0]    = 1'b1;
                        en[2]    = 1'b1;
                    end
                end
                BOM_EFBB:
                begin
                    bom_next = BOM_PAST;
                    if (in_byte != BOM2)
                    begin
                        en = 3'b111;
                    end
                end
                BOM_PAST:
                begin
                    en[2] = 1'b1;
                end
                default:
                begin
                    bom_next = BOM_PAST;
                    en[2]    = 1'b1;
                end
            endcase
        end
    end

    // Three chained parser steps, each passing its state on when disabled.
    always_comb
    begin
        if (en[0])
        begin
            r0 = body_fn(parse, b0);
        end
        else
        begin
            r0    = '0;
            r0.st = parse;
        end
        if (en[1])
        begin
            r1 = body_fn(r0.st, b1);
        end
        else
        begin
            r1    = '0;
            r1.st = r0.st;
        end
        if (en[2])
        begin
            r2 = body_fn(r1.st, b2);
        end
        else
        begin
            r2    = '0;
            r2.st = r1.st;
        end
        eos = '0;
        if (r1.st.field_has_data || r1.st.row_started)
        begin
            eos = rowend_fn(r1.st);
        end
    end

    always_comb
    begin
        toks[0] = r0.tok;
        toks[1] = r1.tok;
        if (cmd)
        begin
            toks[2]    = eos.tok;
            parse_next = '0;
        end
        else
        begin
            toks[2]    = r2.tok;
            parse_next = r2.st;
        end
    end

endmodule

[rtl/core/csv_stream_tokenizer_top.sv]
// Top level of the CSV stream tokenizer: input register, parser state, step
// logic and a four-entry token queue. Depends on cst_pkg and cst_step.
//
//  Channel | Handshake             | Payload                            | Dir
//  --------+-----------------------+------------------------------------+-----
//  byte    | byte_valid/byte_stall | cmd, in_byte                       | in
//  tok     | tok_valid/tok_stall   | kind, out_byte, row_empty, last    | out
//
// A request is accepted into the input register and processed once the token
// queue holds at most one token; its tokens are visible from the cycle after
// that. Requests yielding at most one token flow at one per cycle while the
// token port does not stall; a request yielding two or three tokens (a replayed
// mark, end of stream) holds the input register until the queue holds at most
// one token. Reset clears the parser state, the input register and the queue;
// the first byte after reset is tested for the start of a byte order mark. A
// stall on the token port back-pressures the byte port through the queue.
module csv_stream_tokenizer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic                cmd,
    input  logic [7:0]          in_byte,
    output logic                tok_valid,
    input  logic                tok_stall,
    output logic [1:0]          kind,
    output logic [7:0]          out_byte,
    output logic                row_empty,
    output logic                last
);
    import cst_pkg::*;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

    // Input register.
    logic                ir_valid_reg;
    logic                ir_cmd_reg;
    logic [7:0]          ir_byte_reg;

    // Parser state.
    bom_t                bom_reg;
    bom_t                bom_next;
    parse_t              parse_reg;
    parse_t              parse_next;

    tok_t [MAX_TOKENS-1:0] toks;

    // Token queue.
    kind_t               q_kind_reg  [QDEPTH];
    logic [7:0]          q_data_reg  [QDEPTH];
    logic                q_empty_reg [QDEPTH];
    logic                q_last_reg  [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                fire;
    logic                accept;
    logic                pop;
    logic [PTR_W-1:0]    ofs [MAX_TOKENS];
    logic [1:0]          nwr;
    logic [MAX_TOKENS-1:0] tok_last;

    cst_step u_step (
        .cmd        (ir_cmd_reg),
        .in_byte    (ir_byte_reg),
        .bom_phase  (bom_reg),
        .parse      (parse_reg),
        .bom_next   (bom_next),
        .parse_next (parse_next),
        .toks       (toks)
    );

    // The queue must have room for the largest burst of tokens before a request
    // is processed; this leaves the byte stall free of any path from tok_stall.
    assign fire       = ir_valid_reg && (count_reg <= CNT_W'(QDEPTH - MAX_TOKENS));
    assign byte_stall = ir_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;
    assign tok_valid  = (count_reg != '0);
    assign pop        = tok_valid && !tok_stall;

    // Tokens are packed into consecutive queue slots, skipping empty ones; the
    // final valid token of a request carries the last mark.
    always_comb
    begin
        ofs[0]      = '0;
        ofs[1]      = PTR_W'(toks[0].valid);
        ofs[2]      = PTR_W'(toks[0].valid) + PTR_W'(toks[1].valid);
        nwr         = 2'(toks[0].valid) + 2'(toks[1].valid) + 2'(toks[2].valid);
        tok_last[2] = toks[2].valid;
        tok_last[1] = toks[1].valid && !toks[2].valid;
        tok_last[0] = toks[0].valid && !toks[1].valid && !toks[2].valid;
        count_next  = count_reg - CNT_W'(pop) + (fire ? CNT_W'(nwr) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
            bom_reg      <= BOM_START;
            parse_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                ir_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                ir_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                bom_reg    <= bom_next;
                parse_reg  <= parse_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(nwr);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_cmd_reg  <= cmd;
            ir_byte_reg <= in_byte;
        end
        if (fire)
        begin
            for (int i = 0; i < MAX_TOKENS; i++)
            begin
                if (toks[i].valid)
                begin
                    q_kind_reg[wr_ptr_reg + ofs[i]]  <= toks[i].kind;
                    q_data_reg[wr_ptr_reg + ofs[i]]  <= toks[i].data;
                    q_empty_reg[wr_ptr_reg + ofs[i]] <= toks[i].empty;
                    q_last_reg[wr_ptr_reg + ofs[i]]  <= tok_last[i];
                end
            end
        end
    end

    assign kind      = q_kind_reg[rd_ptr_reg];
    assign out_byte  = q_data_reg[rd_ptr_reg];
    assign row_empty = q_empty_reg[rd_ptr_reg];
    assign last      = q_last_reg[rd_ptr_reg];

endmodule

[rtl/core/cst_checker.sv]
// Port-level checker for the CSV stream tokenizer, bound to the top level.
// Depends on cst_pkg and csv_stream_tokenizer_top.
module cst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic       cmd,
    input logic [7:0] in_byte,
    input logic       tok_valid,
    input logic       tok_stall,
    input logic [1:0] kind,
    input logic [7:0] out_byte,
    input logic       row_empty,
    input logic       last
);
    import cst_pkg::*;

    // Only the three token kinds are ever presented.
    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (kind == KIND_DATA) || (kind == KIND_FIELD) || (kind == KIND_ROW))
        else $error("token kind out of range");

    // Field and row ends carry a zero byte.
    a_ctrl_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (kind != KIND_DATA) |-> (out_byte == 8'd0))
        else $error("non-data token carries a byte");

    // The empty-row flag only appears on a row end.
    a_empty_on_row: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && row_empty |-> (kind == KIND_ROW))
        else $error("row_empty set on a token that is no row end");

    // A stalled token stays presented and unchanged.
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(kind) && $stable(out_byte)
            && $stable(row_empty) && $stable(last))
        else $error("stalled token changed");

    // A stalled request stays offered and unchanged.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(cmd) && $stable(in_byte))
        else $error("stalled request changed");

endmodule

bind csv_stream_tokenizer_top cst_checker u_cst_checker (.*);
